// File: rtl/trajectory_lockstep_distance_unit_macros.svh
// ----------------------------------------------------------------------------
// Trajectory lockstep distance unit: assertion macros
// Concurrent checks sampled on the rising edge of clock, off during reset.
// ----------------------------------------------------------------------------
`ifndef TRAJECTORY_LOCKSTEP_DISTANCE_UNIT_MACROS_SVH
`define TRAJECTORY_LOCKSTEP_DISTANCE_UNIT_MACROS_SVH

// Check that expr holds in the same cycle as cond
`define TLD_ASSERT_HOLDS(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error(msg);

// Check that expr holds in the cycle after cond
`define TLD_ASSERT_NEXT(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error(msg);

`endif

// File: rtl/tld_pkg.sv
// ----------------------------------------------------------------------------
// Trajectory lockstep distance package
// Shared fixed-point constants, queue entry layout and back-end state codes.
// ----------------------------------------------------------------------------
package tld_pkg;

   // Angle constants, Q3.13
   localparam logic signed [15:0] PI_Q      = 16'sd25736;
   localparam logic signed [15:0] BAND_Q    = 16'sd21053;
   localparam logic signed [16:0] TWO_PI_Q  = 17'sd51472;

   // Saturation limits
   localparam logic [62:0] MAX63       = 63'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [62:0] POS_WEIGHT  = 63'd100;
   localparam logic [62:0] POS_LIMIT   = MAX63 / POS_WEIGHT;
   localparam logic [62:0] ANGLE_LIMIT = MAX63 >> 6;
   localparam logic [34:0] SQ_LIMIT    = 35'd3037000499;

   // Decoupling queue between front and back end
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // One classified pair, as handed from front to back end
   typedef struct packed {
      logic signed [33:0] dx;    // A x minus aligned B x
      logic signed [32:0] dy;
      logic signed [32:0] dz;
      logic signed [16:0] da;    // raw angle difference
      logic signed [16:0] td;    // revolution count difference
      logic               last;
   } queue_entry_type;

   // Terms squared in turn by the back end
   typedef enum logic [1:0] {
      TERM_X,
      TERM_Y,
      TERM_Z,
      TERM_ANGLE
   } term_type;

   typedef enum logic [2:0] {
      BACK_IDLE,
      BACK_SQUARE,
      BACK_SUM,
      BACK_SCALE,
      BACK_ACCUM,
      BACK_EMIT
   } back_state_type;

endpackage

// File: rtl/tld_front.sv
// ----------------------------------------------------------------------------
// Trajectory lockstep distance front end
// Aligns B's x to A's start, unwraps both angles and forms the differences.
// ----------------------------------------------------------------------------
module tld_front import tld_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic signed [31:0]    a_pos_x,
   input  logic signed [31:0]    a_pos_y,
   input  logic signed [31:0]    a_pos_z,
   input  logic signed [15:0]    a_angle,
   input  logic signed [31:0]    b_pos_x,
   input  logic signed [31:0]    b_pos_y,
   input  logic signed [31:0]    b_pos_z,
   input  logic signed [15:0]    b_angle,
   input  logic                  last_pair,
   output queue_entry_type       entry
);

   localparam logic signed [15:0] TURN_MAX = 16'sh7FFF;
   localparam logic signed [15:0] TURN_MIN = 16'sh8000;

   logic                first_seen_ff, first_seen_in;
   logic signed [31:0]  start_x_a_ff, start_x_a_in;
   logic signed [31:0]  start_x_b_ff, start_x_b_in;
   logic signed [15:0]  prev_a_ff, prev_a_in;
   logic signed [15:0]  prev_b_ff, prev_b_in;
   logic signed [15:0]  turns_a_ff, turns_a_in;
   logic signed [15:0]  turns_b_ff, turns_b_in;

   logic signed [31:0]  st_a, st_b;
   logic signed [32:0]  diff_x;
   logic signed [31:0]  half_x;
   logic signed [32:0]  bx_aligned;
   logic signed [15:0]  turns_a_next, turns_b_next;

   function automatic logic in_high(input logic signed [15:0] v);
      return (v > BAND_Q) && (v < PI_Q);
   endfunction

   function automatic logic in_low(input logic signed [15:0] v);
      return (v > -PI_Q) && (v < -BAND_Q);
   endfunction

   function automatic logic signed [15:0] step_turns(
      input logic signed [15:0] turns,
      input logic signed [15:0] prev,
      input logic signed [15:0] cur
   );
      logic signed [15:0] res;
      res = turns;
      if (in_high(prev) && in_low(cur)) begin
         if (turns != TURN_MAX) res = turns + 16'sd1;
      end else if (in_high(cur) && in_low(prev)) begin
         if (turns != TURN_MIN) res = turns - 16'sd1;
      end
      return res;
   endfunction

   // Classify the pair: align x, difference positions, unwrap angles
   always_comb begin
      st_a         = first_seen_ff ? start_x_a_ff : a_pos_x;
      st_b         = first_seen_ff ? start_x_b_ff : b_pos_x;
      diff_x       = 33'(b_pos_x) - 33'(st_b);
      half_x       = diff_x[32:1];
      bx_aligned   = 33'(st_a) + 33'(half_x);
      turns_a_next = step_turns(turns_a_ff, prev_a_ff, a_angle);
      turns_b_next = step_turns(turns_b_ff, prev_b_ff, b_angle);

      entry.dx   = 34'(a_pos_x) - 34'(bx_aligned);
      entry.dy   = 33'(a_pos_y) - 33'(b_pos_y);
      entry.dz   = 33'(a_pos_z) - 33'(b_pos_z);
      entry.da   = 17'(a_angle) - 17'(b_angle);
      entry.td   = 17'(turns_a_next) - 17'(turns_b_next);
      entry.last = last_pair;
   end

   // Advance the tracking state on each transfer, drop it after a last pair
   always_comb begin
      first_seen_in = first_seen_ff;
      start_x_a_in  = start_x_a_ff;
      start_x_b_in  = start_x_b_ff;
      prev_a_in     = prev_a_ff;
      prev_b_in     = prev_b_ff;
      turns_a_in    = turns_a_ff;
      turns_b_in    = turns_b_ff;
      if (accept) begin
         if (last_pair) begin
            first_seen_in = 1'b0;
            start_x_a_in  = '0;
            start_x_b_in  = '0;
            prev_a_in     = '0;
            prev_b_in     = '0;
            turns_a_in    = '0;
            turns_b_in    = '0;
         end else begin
            first_seen_in = 1'b1;
            start_x_a_in  = st_a;
            start_x_b_in  = st_b;
            prev_a_in     = a_angle;
            prev_b_in     = b_angle;
            turns_a_in    = turns_a_next;
            turns_b_in    = turns_b_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_seen_ff <= 1'b0;
         start_x_a_ff  <= '0;
         start_x_b_ff  <= '0;
         prev_a_ff     <= '0;
         prev_b_ff     <= '0;
         turns_a_ff    <= '0;
         turns_b_ff    <= '0;
      end else begin
         first_seen_ff <= first_seen_in;
         start_x_a_ff  <= start_x_a_in;
         start_x_b_ff  <= start_x_b_in;
         prev_a_ff     <= prev_a_in;
         prev_b_ff     <= prev_b_in;
         turns_a_ff    <= turns_a_in;
         turns_b_ff    <= turns_b_in;
      end
   end

endmodule

// File: rtl/tld_queue.sv
// ----------------------------------------------------------------------------
// Trajectory lockstep distance queue
// Short first-in first-out buffer of classified pairs between the two ends.
// ----------------------------------------------------------------------------
module tld_queue import tld_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  queue_entry_type  push_data,
   output logic             full,
   input  logic             pop,
   output queue_entry_type  head,
   output logic             empty
);

   queue_entry_type    store_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               do_push, do_pop;

   assign full    = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = store_ff[rd_ptr_ff];
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = do_push ? QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = QCNT_W'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = QCNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Hold entries until read
   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/tld_back.sv
// ----------------------------------------------------------------------------
// Trajectory lockstep distance back end
// Squares the four terms on one shared multiplier, scales, accumulates and
// posts the sums on a last pair.
// ----------------------------------------------------------------------------
module tld_back import tld_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_empty,
   input  queue_entry_type  q_head,
   output logic             q_pop,
   input  logic             rsp_pop,
   output logic             rsp_empty,
   output logic [62:0]      rsp_position_sum,
   output logic [62:0]      rsp_angle_sum,
   output logic [62:0]      rsp_total_distance
);

   back_state_type      state_ff, state_in;
   term_type            term_ff, term_in;
   logic [34:0]         mag_x_ff, mag_x_in;
   logic [34:0]         mag_y_ff, mag_y_in;
   logic [34:0]         mag_z_ff, mag_z_in;
   logic signed [34:0]  ang_raw_ff, ang_raw_in;
   logic                last_ff, last_in;
   logic [62:0]         sq_ff, sq_in;
   logic [62:0]         pos_sum_ff, pos_sum_in;
   logic [62:0]         ang_sq_ff, ang_sq_in;
   logic [62:0]         scaled_ff, scaled_in;
   logic [62:0]         pos_acc_ff, pos_acc_in;
   logic [62:0]         ang_acc_ff, ang_acc_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [62:0]         out_pos_ff, out_pos_in;
   logic [62:0]         out_ang_ff, out_ang_in;
   logic [62:0]         out_total_ff, out_total_in;

   logic signed [33:0]  ang_turn;
   logic [34:0]         sq_mag;
   logic [31:0]         sq_op;
   logic [63:0]         sq_prod;
   logic [62:0]         aligned;
   logic                emit;

   function automatic logic [34:0] abs35(input logic signed [34:0] v);
      return v[34] ? 35'(-v) : 35'(v);
   endfunction

   function automatic logic [62:0] sat_add63(input logic [62:0] a, input logic [62:0] b);
      logic [63:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[63] ? MAX63 : s[62:0];
   endfunction

   assign rsp_empty          = ~rsp_valid_ff;
   assign rsp_position_sum   = out_pos_ff;
   assign rsp_angle_sum      = out_ang_ff;
   assign rsp_total_distance = out_total_ff;

   // Sequence the terms through the shared squaring multiplier
   always_comb begin
      state_in     = state_ff;
      term_in      = term_ff;
      mag_x_in     = mag_x_ff;
      mag_y_in     = mag_y_ff;
      mag_z_in     = mag_z_ff;
      ang_raw_in   = ang_raw_ff;
      last_in      = last_ff;
      sq_in        = sq_ff;
      pos_sum_in   = pos_sum_ff;
      ang_sq_in    = ang_sq_ff;
      scaled_in    = scaled_ff;
      pos_acc_in   = pos_acc_ff;
      ang_acc_in   = ang_acc_ff;
      out_pos_in   = out_pos_ff;
      out_ang_in   = out_ang_ff;
      out_total_in = out_total_ff;
      q_pop        = 1'b0;
      emit         = 1'b0;

      ang_turn = 34'(q_head.td) * 34'(TWO_PI_Q);

      case (term_ff)
         TERM_X:  sq_mag = mag_x_ff;
         TERM_Y:  sq_mag = mag_y_ff;
         TERM_Z:  sq_mag = mag_z_ff;
         default: sq_mag = abs35(ang_raw_ff);
      endcase
      sq_op   = sq_mag[31:0];
      sq_prod = 64'(sq_op) * 64'(sq_op);

      // Align the angle sum to the position scale
      aligned = (ang_acc_ff > ANGLE_LIMIT) ? MAX63 : {ang_acc_ff[56:0], 6'b0};

      case (state_ff)
         BACK_IDLE: begin
            if (!q_empty) begin
               q_pop      = 1'b1;
               mag_x_in   = abs35(35'(q_head.dx));
               mag_y_in   = abs35(35'(q_head.dy));
               mag_z_in   = abs35(35'(q_head.dz));
               ang_raw_in = 35'(ang_turn) + 35'(q_head.da);
               last_in    = q_head.last;
               term_in    = TERM_X;
               pos_sum_in = '0;
               state_in   = BACK_SQUARE;
            end
         end
         BACK_SQUARE: begin
            sq_in    = (sq_mag > SQ_LIMIT) ? MAX63 : sq_prod[62:0];
            state_in = BACK_SUM;
         end
         BACK_SUM: begin
            if (term_ff == TERM_ANGLE) begin
               ang_sq_in = sq_ff;
               state_in  = BACK_SCALE;
            end else begin
               pos_sum_in = sat_add63(pos_sum_ff, sq_ff);
               term_in    = term_type'(term_ff + 1'b1);
               state_in   = BACK_SQUARE;
            end
         end
         BACK_SCALE: begin
            scaled_in = (pos_sum_ff > POS_LIMIT) ? MAX63 : 63'(pos_sum_ff * POS_WEIGHT);
            state_in  = BACK_ACCUM;
         end
         BACK_ACCUM: begin
            pos_acc_in = sat_add63(pos_acc_ff, scaled_ff);
            ang_acc_in = sat_add63(ang_acc_ff, ang_sq_ff);
            state_in   = last_ff ? BACK_EMIT : BACK_IDLE;
         end
         BACK_EMIT: begin
            // Hold until the result slot is free, then post and clear
            if (!rsp_valid_ff) begin
               emit         = 1'b1;
               out_pos_in   = pos_acc_ff;
               out_ang_in   = ang_acc_ff;
               out_total_in = sat_add63(pos_acc_ff, aligned);
               pos_acc_in   = '0;
               ang_acc_in   = '0;
               state_in     = BACK_IDLE;
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase

      rsp_valid_in = (rsp_valid_ff & ~rsp_pop) | emit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         term_ff      <= TERM_X;
         pos_acc_ff   <= '0;
         ang_acc_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         term_ff      <= term_in;
         pos_acc_ff   <= pos_acc_in;
         ang_acc_ff   <= ang_acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      mag_x_ff     <= mag_x_in;
      mag_y_ff     <= mag_y_in;
      mag_z_ff     <= mag_z_in;
      ang_raw_ff   <= ang_raw_in;
      last_ff      <= last_in;
      sq_ff        <= sq_in;
      pos_sum_ff   <= pos_sum_in;
      ang_sq_ff    <= ang_sq_in;
      scaled_ff    <= scaled_in;
      out_pos_ff   <= out_pos_in;
      out_ang_ff   <= out_ang_in;
      out_total_ff <= out_total_in;
   end

endmodule

// File: rtl/trajectory_lockstep_distance_unit.sv
// ----------------------------------------------------------------------------
// Trajectory lockstep distance unit: posts the sums on rsp after a last pair's transfer.
// The back end takes one pair at a time, with four passes over one 32x32 squarer, and the
// front end takes a pair per cycle until its two-entry queue is full.
// Synchronous reset clears unwrap state, accumulators, queue and result slot.
// ----------------------------------------------------------------------------
`include "trajectory_lockstep_distance_unit_macros.svh"

module trajectory_lockstep_distance_unit import tld_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  logic signed [31:0]  req_a_pos_x,
   input  logic signed [31:0]  req_a_pos_y,
   input  logic signed [31:0]  req_a_pos_z,
   input  logic signed [15:0]  req_a_angle,
   input  logic signed [31:0]  req_b_pos_x,
   input  logic signed [31:0]  req_b_pos_y,
   input  logic signed [31:0]  req_b_pos_z,
   input  logic signed [15:0]  req_b_angle,
   input  logic                req_last_pair,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output logic [62:0]         rsp_position_sum,
   output logic [62:0]         rsp_angle_sum,
   output logic [62:0]         rsp_total_distance
);

   logic             q_full, q_empty, q_pop, q_push;
   queue_entry_type  front_entry, q_head;

   // Take a pair whenever the queue has room
   assign q_push   = req_push & ~q_full;
   assign req_full = q_full;

   tld_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (q_push),
      .a_pos_x   (req_a_pos_x),
      .a_pos_y   (req_a_pos_y),
      .a_pos_z   (req_a_pos_z),
      .a_angle   (req_a_angle),
      .b_pos_x   (req_b_pos_x),
      .b_pos_y   (req_b_pos_y),
      .b_pos_z   (req_b_pos_z),
      .b_angle   (req_b_angle),
      .last_pair (req_last_pair),
      .entry     (front_entry)
   );

   tld_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (front_entry),
      .full      (q_full),
      .pop       (q_pop),
      .head      (q_head),
      .empty     (q_empty)
   );

   tld_back u_back (
      .clock              (clock),
      .reset              (reset),
      .q_empty            (q_empty),
      .q_head             (q_head),
      .q_pop              (q_pop),
      .rsp_pop            (rsp_pop),
      .rsp_empty          (rsp_empty),
      .rsp_position_sum   (rsp_position_sum),
      .rsp_angle_sum      (rsp_angle_sum),
      .rsp_total_distance (rsp_total_distance)
   );

   // Saturating total never falls below either of its terms
   `TLD_ASSERT_HOLDS(a_total_ge_pos, !rsp_empty, rsp_total_distance >= rsp_position_sum, "total below position sum")
   `TLD_ASSERT_HOLDS(a_total_ge_ang, !rsp_empty, rsp_total_distance >= rsp_angle_sum, "total below angle sum")
   `TLD_ASSERT_HOLDS(a_total_no_ang, !rsp_empty && rsp_angle_sum == '0, rsp_total_distance == rsp_position_sum, "total differs with zero angle sum")
   // A full queue stays full until the back end reads it
   `TLD_ASSERT_NEXT(a_queue_holds, q_full && !q_pop, q_full, "queue lost an entry without a read")

endmodule

// File: tb/sv/tld_distance_check_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trajectory lockstep distance testbench: sample pairs and distance scoreboard
// Holds the layout of one sample pair and one set of sums, and a scoreboard
// that tracks both trajectories, predicts the sums due on every last pair and
// checks each set the unit hands out against the oldest prediction.
// ----------------------------------------------------------------------------
package tld_distance_check_pkg;

   // Saturation ceilings and weights
   localparam logic [63:0]     SUM_CEILING     = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0]     POSITION_WEIGHT = 64'd100;
   localparam longint unsigned SQUARE_CEILING  = 64'd3037000499;

   // Heading constants, Q3.13
   localparam int     HALF_TURN = 25736;
   localparam int     BAND_EDGE = 21053;
   localparam longint FULL_TURN = 51472;
   localparam int     TURNS_MAX = 32767;
   localparam int     TURNS_MIN = -32768;

   typedef struct packed {
      logic signed [31:0] a_pos_x;
      logic signed [31:0] a_pos_y;
      logic signed [31:0] a_pos_z;
      logic signed [15:0] a_angle;
      logic signed [31:0] b_pos_x;
      logic signed [31:0] b_pos_y;
      logic signed [31:0] b_pos_z;
      logic signed [15:0] b_angle;
      logic               last_pair;
   } sample_pair_type;

   typedef struct packed {
      logic [62:0] position_sum;
      logic [62:0] angle_sum;
      logic [62:0] total_distance;
   } distance_sums_type;

   function automatic logic [63:0] clamp_add(logic [63:0] lhs, logic [63:0] rhs);
      if (lhs > SUM_CEILING || rhs > SUM_CEILING - lhs) return SUM_CEILING;
      return lhs + rhs;
   endfunction

   // Square a difference, pinning anything too large to the ceiling
   function automatic logic [63:0] clamp_square(longint delta);
      longint unsigned magnitude;
      if (delta < 0) magnitude = -delta;
      else magnitude = delta;
      if (magnitude > SQUARE_CEILING) return SUM_CEILING;
      return magnitude * magnitude;
   endfunction

   function automatic bit in_upper_band(int heading);
      return heading > BAND_EDGE && heading < HALF_TURN;
   endfunction

   function automatic bit in_lower_band(int heading);
      return heading > -HALF_TURN && heading < -BAND_EDGE;
   endfunction

   // Count a crossing of the +/-pi seam, in either direction
   function automatic int advance_turns(int turns, int previous, int current);
      if (in_upper_band(previous) && in_lower_band(current)) begin
         if (turns < TURNS_MAX) return turns + 1;
      end else if (in_upper_band(current) && in_lower_band(previous)) begin
         if (turns > TURNS_MIN) return turns - 1;
      end
      return turns;
   endfunction

   class distance_scoreboard;
      bit                anchored;
      longint            anchor_x_a;
      longint            anchor_x_b;
      int                heading_a;
      int                heading_b;
      int                turns_a;
      int                turns_b;
      logic [63:0]       position_acc;
      logic [63:0]       angle_acc;
      distance_sums_type awaited_sums[$];
      int                mismatches;

      function new();
         restart_track();
         mismatches = 0;
      endfunction

      function void restart_track();
         anchored     = 1'b0;
         anchor_x_a   = 0;
         anchor_x_b   = 0;
         heading_a    = 0;
         heading_b    = 0;
         turns_a      = 0;
         turns_b      = 0;
         position_acc = '0;
         angle_acc    = '0;
      endfunction

      // Fold one accepted pair into the track; a last pair yields a set of sums
      function void note_pair(sample_pair_type pair);
         longint            ax, ay, az, bx, by, bz, halved, dx;
         int                aa, ba;
         logic [63:0]       position_term, angle_term, aligned, total;
         distance_sums_type sums;
         ax = longint'($signed(pair.a_pos_x));
         ay = longint'($signed(pair.a_pos_y));
         az = longint'($signed(pair.a_pos_z));
         bx = longint'($signed(pair.b_pos_x));
         by = longint'($signed(pair.b_pos_y));
         bz = longint'($signed(pair.b_pos_z));
         aa = int'($signed(pair.a_angle));
         ba = int'($signed(pair.b_angle));

         // Latch the start x of both trajectories
         if (!anchored) begin
            anchor_x_a = ax;
            anchor_x_b = bx;
            anchored   = 1'b1;
         end

         // Halve B about its start, rounding down, and move it onto A's start
         halved = (bx - anchor_x_b) >>> 1;
         dx     = ax - (anchor_x_a + halved);

         position_term = clamp_add(clamp_add(clamp_square(dx), clamp_square(ay - by)),
                                   clamp_square(az - bz));
         if (position_term > SUM_CEILING / POSITION_WEIGHT) position_term = SUM_CEILING;
         else position_term = position_term * POSITION_WEIGHT;
         position_acc = clamp_add(position_acc, position_term);

         // Unwrap both headings
         turns_a   = advance_turns(turns_a, heading_a, aa);
         turns_b   = advance_turns(turns_b, heading_b, ba);
         heading_a = aa;
         heading_b = ba;
         angle_term = clamp_square(longint'(aa) - longint'(ba) +
                                   FULL_TURN * (longint'(turns_a) - longint'(turns_b)));
         angle_acc = clamp_add(angle_acc, angle_term);

         if (pair.last_pair) begin
            aligned = (angle_acc > (SUM_CEILING >> 6)) ? SUM_CEILING : (angle_acc << 6);
            total   = clamp_add(position_acc, aligned);
            sums.position_sum   = position_acc[62:0];
            sums.angle_sum      = angle_acc[62:0];
            sums.total_distance = total[62:0];
            awaited_sums.insert(awaited_sums.size(), sums);
            restart_track();
         end
      endfunction

      function void compare_field(string name, logic [62:0] want, logic [62:0] got);
         if (want !== got) begin
            if (mismatches < 10)
               $display("%0t: %s expected %0d got %0d", $realtime, name, want, got);
            mismatches++;
         end
      endfunction

      // Check one transferred set of sums against the oldest prediction
      function void check_sums(distance_sums_type got);
         distance_sums_type want;
         if (awaited_sums.size() == 0) begin
            if (mismatches < 10)
               $display("%0t: sums with none outstanding: %0d %0d %0d", $realtime,
                        got.position_sum, got.angle_sum, got.total_distance);
            mismatches++;
            return;
         end
         want = awaited_sums.pop_front();
         compare_field("position_sum", want.position_sum, got.position_sum);
         compare_field("angle_sum", want.angle_sum, got.angle_sum);
         compare_field("total_distance", want.total_distance, got.total_distance);
      endfunction

      function int outstanding();
         return awaited_sums.size();
      endfunction

      function int failures();
         return mismatches + awaited_sums.size();
      endfunction
   endclass

endpackage

// File: tb/sv/tb_trajectory_lockstep_distance_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trajectory lockstep distance unit testbench
// Streams directed and random trajectory pairs through the unit in bursts,
// pops the sums with a stall pattern of its own, including one long hold-off
// that backs the unit up, and checks every set against the scoreboard.
// ----------------------------------------------------------------------------
module tb_trajectory_lockstep_distance_unit;
   import tld_distance_check_pkg::*;

   // A correct run of about 1500 pairs, with sender gaps and receiver stalls,
   // ends well before the cycle limit
   localparam int CYCLE_LIMIT     = 600000;
   localparam int TARGET_PAIRS    = 1450;
   localparam int DRAIN_CYCLES    = 60;
   localparam int HOLD_OFF_CYCLES = 400;

   localparam logic signed [31:0] POS_MIN   = 32'sh8000_0000;
   localparam logic signed [31:0] POS_MAX   = 32'sh7FFF_FFFF;
   localparam logic signed [15:0] ANGLE_MIN = 16'sh8000;
   localparam logic signed [15:0] ANGLE_MAX = 16'sh7FFF;

   logic               clock;
   logic               reset;
   logic               req_push;
   logic               req_full;
   logic signed [31:0] req_a_pos_x;
   logic signed [31:0] req_a_pos_y;
   logic signed [31:0] req_a_pos_z;
   logic signed [15:0] req_a_angle;
   logic signed [31:0] req_b_pos_x;
   logic signed [31:0] req_b_pos_y;
   logic signed [31:0] req_b_pos_z;
   logic signed [15:0] req_b_angle;
   logic               req_last_pair;
   logic               rsp_empty;
   logic               rsp_pop;
   logic [62:0]        rsp_position_sum;
   logic [62:0]        rsp_angle_sum;
   logic [62:0]        rsp_total_distance;

   distance_scoreboard sums_board = new();
   sample_pair_type    pair_stream[$];
   int                 cycle_count = 0;
   int                 sums_received = 0;

   trajectory_lockstep_distance_unit dut (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_a_pos_x        (req_a_pos_x),
      .req_a_pos_y        (req_a_pos_y),
      .req_a_pos_z        (req_a_pos_z),
      .req_a_angle        (req_a_angle),
      .req_b_pos_x        (req_b_pos_x),
      .req_b_pos_y        (req_b_pos_y),
      .req_b_pos_z        (req_b_pos_z),
      .req_b_angle        (req_b_angle),
      .req_last_pair      (req_last_pair),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_position_sum   (rsp_position_sum),
      .rsp_angle_sum      (rsp_angle_sum),
      .rsp_total_distance (rsp_total_distance)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic sample_pair_type make_pair(int ax, int ay, int az, int aa,
                                                  int bx, int by, int bz, int ba, bit last);
      sample_pair_type pair;
      pair.a_pos_x   = ax;
      pair.a_pos_y   = ay;
      pair.a_pos_z   = az;
      pair.a_angle   = 16'(aa);
      pair.b_pos_x   = bx;
      pair.b_pos_y   = by;
      pair.b_pos_z   = bz;
      pair.b_angle   = 16'(ba);
      pair.last_pair = last;
      return pair;
   endfunction

   // Append one pair to the end of the stream
   task automatic append_pair(sample_pair_type pair);
      pair_stream.insert(pair_stream.size(), pair);
   endtask

   function automatic int spread(int reach);
      return int'($urandom_range(0, 2 * reach)) - reach;
   endfunction

   // Fold a heading back into [-pi, pi)
   function automatic int wrap_heading(int heading);
      while (heading >= HALF_TURN) heading -= int'(FULL_TURN);
      while (heading < -HALF_TURN) heading += int'(FULL_TURN);
      return heading;
   endfunction

   task automatic add_directed_pairs();
      // All zero, one pair long
      append_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
      // Extreme y, z and heading: y and z squares and the total pinned at the ceiling
      append_pair(make_pair(0, POS_MAX, POS_MIN, ANGLE_MAX,
                            0, POS_MIN, POS_MAX, ANGLE_MIN, 1'b1));
      // Extreme x: the start latches, then B swings across the full range
      append_pair(make_pair(POS_MIN, 0, 0, 0, POS_MAX, 0, 0, 0, 1'b0));
      append_pair(make_pair(POS_MAX, 0, 0, 0, POS_MIN, 0, 0, 0, 1'b1));
      // Halving of odd offsets rounds down
      append_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
      append_pair(make_pair(0, 0, 0, 0, -1, 0, 0, 0, 1'b0));
      append_pair(make_pair(0, 0, 0, 0, -3, 0, 0, 0, 1'b0));
      append_pair(make_pair(0, 0, 0, 0, 3, 0, 0, 0, 1'b1));
      // Seam crossings both ways, then headings right on the band edges
      append_pair(make_pair(0, 0, 0, 22000, 0, 0, 0, -22000, 1'b0));
      append_pair(make_pair(0, 0, 0, -22000, 0, 0, 0, 22000, 1'b0));
      append_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
      append_pair(make_pair(0, 0, 0, 22000, 0, 0, 0, -22000, 1'b0));
      append_pair(make_pair(0, 0, 0, -22000, 0, 0, 0, 22000, 1'b0));
      append_pair(make_pair(0, 0, 0, 21053, 0, 0, 0, 25736, 1'b0));
      append_pair(make_pair(0, 0, 0, -21053, 0, 0, 0, -25736, 1'b0));
      append_pair(make_pair(0, 0, 0, 25735, 0, 0, 0, -25735, 1'b0));
      append_pair(make_pair(0, 0, 0, -25735, 0, 0, 0, 25735, 1'b1));
      // Accumulator runs past the ceiling without any single term saturating
      append_pair(make_pair(0, 230000000, 0, 0, 0, 0, 0, 0, 1'b0));
      append_pair(make_pair(0, 230000000, 0, 0, 0, 0, 0, 0, 1'b1));
      // Weighted term saturates while the square does not
      append_pair(make_pair(0, 1 << 30, 0, 0, 0, -(1 << 30), 0, 0, 1'b1));
      // Square right at and just past its limit
      append_pair(make_pair(0, 0, POS_MAX, 0, 0, 0, -889516852, 0, 1'b1));
      append_pair(make_pair(0, 0, POS_MAX, 0, 0, 0, -889516853, 0, 1'b1));
   endtask

   // Queue one random trajectory pair sequence, closed by a last pair
   task automatic add_trajectory();
      int                 kind, span, scale, drift, offset, spin_a, spin_b, head_a, head_b;
      logic signed [31:0] ax, ay, az, bx, by, bz;
      sample_pair_type    pair;
      kind = $urandom_range(0, 9);
      if (kind < 2) begin
         // Noise: every field free
         span = $urandom_range(1, 6);
         for (int i = 0; i < span; i++) begin
            pair.a_pos_x   = $urandom;
            pair.a_pos_y   = $urandom;
            pair.a_pos_z   = $urandom;
            pair.a_angle   = 16'($urandom);
            pair.b_pos_x   = $urandom;
            pair.b_pos_y   = $urandom;
            pair.b_pos_z   = $urandom;
            pair.b_angle   = 16'($urandom);
            pair.last_pair = (i == span - 1);
            append_pair(pair);
         end
         return;
      end

      // Smooth walks; long spinning runs now and then
      span  = (kind == 2) ? $urandom_range(60, 150) : $urandom_range(1, 30);
      scale = $urandom_range(0, 2);
      drift = (scale == 0) ? (1 << 10) : (scale == 1) ? (1 << 14) : (1 << 24);
      offset = (scale == 0) ? (1 << 14) : (1 << 22);
      ax = $urandom;
      ay = $urandom;
      az = $urandom;
      if (scale < 2) begin
         ax = ax >>> (scale == 0 ? 15 : 7);
         ay = ay >>> (scale == 0 ? 15 : 7);
         az = az >>> (scale == 0 ? 15 : 7);
         bx = ax + spread(offset);
         by = ay + spread(offset);
         bz = az + spread(offset);
      end else begin
         bx = $urandom;
         by = $urandom;
         bz = $urandom;
      end
      head_a = int'($urandom_range(0, 51471)) - HALF_TURN;
      head_b = int'($urandom_range(0, 51471)) - HALF_TURN;
      spin_a = spread(4000);
      spin_b = spread(4000);
      for (int i = 0; i < span; i++) begin
         ax = ax + spread(drift);
         ay = ay + spread(drift);
         az = az + spread(drift);
         bx = bx + spread(drift);
         by = by + spread(drift);
         bz = bz + spread(drift);
         head_a = wrap_heading(head_a + spin_a + spread(300));
         head_b = wrap_heading(head_b + spin_b + spread(300));
         append_pair(make_pair(ax, ay, az, head_a, bx, by, bz, head_b, i == span - 1));
      end
   endtask

   task automatic drive_pair(sample_pair_type pair);
      req_a_pos_x   <= pair.a_pos_x;
      req_a_pos_y   <= pair.a_pos_y;
      req_a_pos_z   <= pair.a_pos_z;
      req_a_angle   <= pair.a_angle;
      req_b_pos_x   <= pair.b_pos_x;
      req_b_pos_y   <= pair.b_pos_y;
      req_b_pos_z   <= pair.b_pos_z;
      req_b_angle   <= pair.b_angle;
      req_last_pair <= pair.last_pair;
   endtask

   // Offer the stream in bursts with random gaps; note each transfer
   task automatic send_stream();
      int burst, gap, next;
      next = 0;
      while (next < pair_stream.size()) begin
         burst = $urandom_range(1, 24);
         for (int k = 0; k < burst && next < pair_stream.size(); k++) begin
            drive_pair(pair_stream[next]);
            req_push <= 1'b1;
            @(posedge clock);
            while (req_full) @(posedge clock);
            sums_board.note_pair(pair_stream[next]);
            next++;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
         if (gap > 0) begin
            req_push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_push <= 1'b0;
   endtask

   // Receiver: pop on a pattern of its own, with one long hold-off
   initial begin
      int                mode, mode_left, stall_left, hold_left;
      bit                hold_used;
      distance_sums_type got;
      rsp_pop   <= 1'b0;
      mode       = 0;
      mode_left  = 0;
      stall_left = 0;
      hold_left  = 0;
      hold_used  = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rsp_pop && !rsp_empty) begin
            got.position_sum   = rsp_position_sum;
            got.angle_sum      = rsp_angle_sum;
            got.total_distance = rsp_total_distance;
            sums_board.check_sums(got);
            sums_received++;
         end
         if (!hold_used && sums_received == 4) begin
            hold_used = 1'b1;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode      = $urandom_range(0, 2);
               mode_left = $urandom_range(20, 80);
            end
            mode_left--;
            case (mode)
               0: begin
                  rsp_pop <= 1'b1;
               end
               1: begin
                  rsp_pop <= ($urandom_range(0, 9) < 6);
               end
               default: begin
                  if (stall_left > 0) begin
                     stall_left--;
                     rsp_pop <= 1'b0;
                  end else begin
                     stall_left = $urandom_range(1, 40);
                     rsp_pop <= 1'b1;
                  end
               end
            endcase
         end
         @(posedge clock);
      end
   end

   // Reset, stimulus and end of run
   initial begin
      reset    <= 1'b1;
      req_push <= 1'b0;
      drive_pair('0);
      add_directed_pairs();
      while (pair_stream.size() < TARGET_PAIRS) add_trajectory();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      send_stream();
      while (sums_board.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sums_board.failures() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
